// ===== rtl/lockable_lifo_stack_macros.svh =====
// Assertion macros for the lockable LIFO stack.
`ifndef LOCKABLE_LIFO_STACK_MACROS_SVH
`define LOCKABLE_LIFO_STACK_MACROS_SVH
`ifndef SYNTHESIS
// Same-cycle implication, disabled while in reset.
`define LLS_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("lls assertion failed");
// Next-cycle implication, disabled while in reset.
`define LLS_ASSERT_NXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("lls assertion failed");
`else
`define LLS_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define LLS_ASSERT_NXT(label, clk, rst_n, ante, cons)
`endif
`endif

// ===== rtl/lls_pkg.sv =====
// Shared types and constants for the lockable LIFO stack.
package lls_pkg;

  localparam int DefStackDepth = 256;
  localparam int DefLockDepth  = 16;
  localparam int DefWordWidth  = 32;
  localparam int ValueW        = 32;
  localparam int LevelW        = 9;
  localparam int KindW         = 3;

  typedef enum logic [KindW-1:0] {
    KIND_PUSH   = 3'd0,
    KIND_POP    = 3'd1,
    KIND_LOCK   = 3'd2,
    KIND_UNLOCK = 3'd3,
    KIND_QUERY  = 3'd4
  } kind_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_POP,
    ST_UNLK
  } state_e;

  typedef struct packed {
    logic [KindW-1:0]  kind;
    logic [ValueW-1:0] push_value;
    logic              override_lock;
  } in_t;

  typedef struct packed {
    logic              ok;
    logic [ValueW-1:0] popped_value;
    logic [LevelW-1:0] level;
  } out_t;

endpackage

// ===== rtl/lls_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module lls_ram #(
  parameter int Width = 32,
  parameter int Depth = 16,
  parameter int AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // registered read port
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/lockable_lifo_stack.sv =====
// Lockable LIFO stack: data words in one RAM, lock floors in a second RAM.
// Push, lock, query, refused pop, first-floor unlock: result in the cycle after the beat.
// Successful pop and unlock onto an older floor: RAM read register, then result register.
// One item in flight: one item per cycle while results are taken, none during a RAM read.
// Reset clears the counters, the cached floor and the output valid flag; RAM contents are
// left as they are and need no clearing pass.
`include "lockable_lifo_stack_macros.svh"

module lockable_lifo_stack
  import lls_pkg::*;
#(
  parameter int STACK_DEPTH = DefStackDepth,
  parameter int LOCK_DEPTH  = DefLockDepth,
  parameter int WORD_WIDTH  = DefWordWidth
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_ready_o,
  input  in_t  in_data_i,
  output logic out_valid_o,
  input  logic out_ready_i,
  output out_t out_data_o
);

  localparam int CntW   = $clog2(STACK_DEPTH + 1);
  localparam int DataAw = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
  localparam int FcW    = $clog2(LOCK_DEPTH + 1);
  localparam int LockAw = (LOCK_DEPTH > 1) ? $clog2(LOCK_DEPTH) : 1;

  state_e state_q, state_d;
  logic [CntW-1:0] cnt_q, cnt_d, cnt_dec;
  logic [FcW-1:0]  fc_q, fc_d, fc_dec, fc_dec2;
  logic [CntW-1:0] floor_q, floor_d;
  logic            out_valid_q, out_valid_d;
  out_t            out_q, res;
  logic            res_load;

  logic            in_ready, in_fire;
  kind_e           kind;
  logic            pop_ok, deep_unlock;

  logic                  d_we, d_re, f_we, f_re;
  logic [WORD_WIDTH-1:0] d_wdata, d_rdata;
  logic [CntW-1:0]       f_rdata;

  // item decode
  assign kind        = kind_e'(in_data_i.kind);
  assign cnt_dec     = cnt_q - CntW'(1);
  assign fc_dec      = fc_q - FcW'(1);
  assign fc_dec2     = fc_q - FcW'(2);
  assign pop_ok      = (cnt_q != '0) && (in_data_i.override_lock || (cnt_q > floor_q));
  assign deep_unlock = fc_q > FcW'(1);
  assign d_wdata     = WORD_WIDTH'(in_data_i.push_value);

  assign in_ready = (state_q == ST_IDLE) && (!out_valid_q || out_ready_i);
  assign in_fire  = in_valid_i && in_ready;

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_fire && (kind == KIND_POP) && pop_ok) begin
          state_d = ST_POP;
        end else if (in_fire && (kind == KIND_UNLOCK) && deep_unlock) begin
          state_d = ST_UNLK;
        end
      end
      ST_POP:  state_d = ST_IDLE;
      ST_UNLK: state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  // datapath control and result
  always_comb begin
    cnt_d    = cnt_q;
    fc_d     = fc_q;
    floor_d  = floor_q;
    d_we     = 1'b0;
    d_re     = 1'b0;
    f_we     = 1'b0;
    f_re     = 1'b0;
    res_load = 1'b0;
    res      = '0;
    case (state_q)
      ST_IDLE: begin
        if (in_fire) begin
          case (kind)
            KIND_PUSH: begin
              res_load = 1'b1;
              if (cnt_q < CntW'(STACK_DEPTH)) begin
                d_we   = 1'b1;
                cnt_d  = cnt_q + CntW'(1);
                res.ok = 1'b1;
              end
            end
            KIND_POP: begin
              if (pop_ok) begin
                d_re  = 1'b1;
                cnt_d = cnt_dec;
              end else begin
                res_load = 1'b1;
              end
            end
            KIND_LOCK: begin
              res_load = 1'b1;
              if (cnt_q == '0) begin
                res.ok = 1'b1;
              end else if (fc_q < FcW'(LOCK_DEPTH)) begin
                f_we      = 1'b1;
                fc_d      = fc_q + FcW'(1);
                floor_d   = cnt_q;
                res.ok    = 1'b1;
                res.level = LevelW'(cnt_q);
              end
            end
            KIND_UNLOCK: begin
              if (deep_unlock) begin
                // older floor comes back from the floor RAM next cycle
                f_re = 1'b1;
                fc_d = fc_dec;
              end else begin
                res_load = 1'b1;
                res.ok   = 1'b1;
                if (fc_q != '0) begin
                  fc_d    = fc_dec;
                  floor_d = '0;
                end
              end
            end
            KIND_QUERY: begin
              res_load = 1'b1;
              res.ok   = 1'b1;
              if (cnt_q > floor_q) begin
                res.level = LevelW'(cnt_q - floor_q);
              end
            end
            default: res_load = 1'b1;
          endcase
        end
      end
      ST_POP: begin
        res_load         = 1'b1;
        res.ok           = 1'b1;
        res.popped_value = ValueW'(d_rdata);
      end
      ST_UNLK: begin
        res_load  = 1'b1;
        res.ok    = 1'b1;
        res.level = LevelW'(f_rdata);
        floor_d   = f_rdata;
      end
      default: ;
    endcase
  end

  assign out_valid_d = res_load ? 1'b1 : (out_valid_q && !out_ready_i);

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cnt_q       <= '0;
      fc_q        <= '0;
      floor_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      fc_q        <= fc_d;
      floor_q     <= floor_d;
      out_valid_q <= out_valid_d;
    end
  end

  // result register
  always_ff @(posedge clk_i) begin
    if (res_load) begin
      out_q <= res;
    end
  end

  // data words
  lls_ram #(
    .Width (WORD_WIDTH),
    .Depth (STACK_DEPTH),
    .AddrW (DataAw)
  ) u_data_ram (
    .clk_i   (clk_i),
    .we_i    (d_we),
    .waddr_i (cnt_q[DataAw-1:0]),
    .wdata_i (d_wdata),
    .re_i    (d_re),
    .raddr_i (cnt_dec[DataAw-1:0]),
    .rdata_o (d_rdata)
  );

  // lock floors
  lls_ram #(
    .Width (CntW),
    .Depth (LOCK_DEPTH),
    .AddrW (LockAw)
  ) u_floor_ram (
    .clk_i   (clk_i),
    .we_i    (f_we),
    .waddr_i (fc_q[LockAw-1:0]),
    .wdata_i (cnt_q),
    .re_i    (f_re),
    .raddr_i (fc_dec2[LockAw-1:0]),
    .rdata_o (f_rdata)
  );

  assign in_ready_o  = in_ready;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // checks
  `LLS_ASSERT_IMP(a_cnt_bound, clk_i, rst_ni, 1'b1, cnt_q <= CntW'(STACK_DEPTH))
  `LLS_ASSERT_IMP(a_no_floor_zero, clk_i, rst_ni, fc_q == '0, floor_q == '0)
  `LLS_ASSERT_NXT(a_pop_reads, clk_i, rst_ni, state_d == ST_POP, state_q == ST_POP && !out_valid_q)

endmodule
